// File: rtl/tet_pkg.sv
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types and constants of the token expiry table: table depth, field
// widths, operation codes and the word layouts of both channels.
// ----------------------------------------------------------------------------
package tet_pkg;

  localparam int ENTRIES = 2048;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 25;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 12;
  localparam int SLOT_W  = KEY_W + TIME_W;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [KIND_W-1:0] KIND_GENERATE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RENEW    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_COUNT    = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  token_key;
    logic [TIME_W-1:0] current_time;
  } in_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0] unexpired_count;
    logic               renew_done;
    logic               table_full;
  } out_word_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] stamp;
  } slot_t;

endpackage

// File: rtl/tet_ram.sv
// ----------------------------------------------------------------------------
// tet_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module tet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/token_expiry_table_top.sv
// ----------------------------------------------------------------------------
// token_expiry_table_top
// Keyed table of ENTRIES slots, each holding a key and the time of its last
// generate or renew; a slot expires once (now - time) mod 2^32 reaches the
// configured time to live. Every word yields one result word. Slots are taken
// from the bottom of the table and never released, so a fill count stands in
// for the used flags and no clearing pass follows reset. For each item the N
// slots taken so far (N from 0 to ENTRIES) are scanned: the slot memory has
// one read port and every taken slot is read once per item, one slot a cycle,
// followed by a step that decides and writes back. One item is worked on at a
// time; a new word is taken while the previous result still waits in the
// output register.
// ----------------------------------------------------------------------------
module token_expiry_table_top
  import tet_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_word_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_word_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [TIME_W-1:0] cfg_data
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(ENTRIES);

  logic [1:0]         state_r, state_nxt;
  logic [TIME_W-1:0]  ttl_r;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic [CNT_W-1:0]   addr_r, addr_nxt;
  in_word_t           item_r;
  logic               rv_r;
  logic [IDX_W-1:0]   ra_r;
  logic               hit_r, hit_nxt;
  logic               hit_live_r, hit_live_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic               free_r, free_nxt;
  logic [IDX_W-1:0]   free_idx_r, free_idx_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;
  logic               out_valid_r;
  out_word_t          out_data_r, result;

  logic               in_accept, issue, out_free, finish;
  logic               we;
  logic [IDX_W-1:0]   waddr;
  slot_t              wslot, rslot;
  logic [TIME_W-1:0]  age;
  logic               live, match;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign finish    = (state_r == ST_FINISH) && out_free;
  assign issue     = (state_r == ST_SCAN) && (addr_r != fill_r);

  tet_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (ENTRIES)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wslot),
    .re    (issue),
    .raddr (addr_r[IDX_W-1:0]),
    .rdata (rslot)
  );

  // slot evaluation on returning read data
  assign age   = item_r.current_time - rslot.stamp;
  assign live  = (age < ttl_r);
  assign match = (rslot.key == item_r.token_key);

  always_comb begin
    hit_nxt      = hit_r;
    hit_live_nxt = hit_live_r;
    hit_idx_nxt  = hit_idx_r;
    free_nxt     = free_r;
    free_idx_nxt = free_idx_r;
    count_nxt    = count_r;
    if (in_accept) begin
      hit_nxt   = 1'b0;
      free_nxt  = 1'b0;
      count_nxt = '0;
    end else if (rv_r) begin
      if (match && !hit_r) begin
        hit_nxt      = 1'b1;
        hit_live_nxt = live;
        hit_idx_nxt  = ra_r;
      end
      if (!live && !free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = ra_r;
      end
      if (live && (count_r != COUNT_MAX)) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // decision and write-back
  always_comb begin
    we       = 1'b0;
    waddr    = hit_idx_r;
    fill_nxt = fill_r;
    result   = '0;
    wslot.key   = item_r.token_key;
    wslot.stamp = item_r.current_time;
    unique case (item_r.kind)
      KIND_GENERATE: begin
        if (hit_r) begin
          we = finish;
        end else if (free_r) begin
          we    = finish;
          waddr = free_idx_r;
        end else if (fill_r != FULL_FILL) begin
          we    = finish;
          waddr = fill_r[IDX_W-1:0];
          if (finish) begin
            fill_nxt = fill_r + 1'b1;
          end
        end else begin
          result.table_full = 1'b1;
        end
      end
      KIND_RENEW: begin
        if (hit_r && hit_live_r) begin
          we                = finish;
          result.renew_done = 1'b1;
        end
      end
      KIND_COUNT: begin
        result.unexpired_count = count_r;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    addr_nxt  = addr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_SCAN;
          addr_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          addr_nxt = addr_r + 1'b1;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ttl_r       <= TIME_W'(1);
      fill_r      <= '0;
      rv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      hit_r       <= 1'b0;
      free_r      <= 1'b0;
      count_r     <= '0;
      addr_r      <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      rv_r    <= issue;
      addr_r  <= addr_nxt;
      hit_r   <= hit_nxt;
      free_r  <= free_nxt;
      count_r <= count_nxt;
      if (cfg_valid && cfg_ready) begin
        ttl_r <= cfg_data;
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ra_r         <= addr_r[IDX_W-1:0];
    hit_live_r   <= hit_live_nxt;
    hit_idx_r    <= hit_idx_nxt;
    free_idx_r   <= free_idx_nxt;
    if (in_accept) begin
      item_r <= in_data;
    end
    if (finish) begin
      out_data_r <= result;
    end
  end

  // checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FULL_FILL)
    else $error("fill count beyond table depth");

  a_no_read_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH) |-> !rv_r)
    else $error("read data still returning at write-back");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_SCAN) && (addr_r == '0))
    else $error("accepted word did not start a scan");

  a_full_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (finish && result.table_full) |-> (fill_r == FULL_FILL) && !free_r && !hit_r)
    else $error("table full flagged with room left");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.renew_done && out_data_r.table_full))
    else $error("renew and full flags both set");

endmodule

// File: tb/sv/token_expiry_table_checker.sv
// ----------------------------------------------------------------------------
// token_expiry_table_checker
// Watches the input, result and configuration channels of the token expiry
// table. It keeps its own copy of the slots and the time to live, works out
// the result word of every accepted input word, and compares each accepted
// result word field by field with the oldest one still due.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_expiry_table_checker
  import tet_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  in_word_t          in_data,
  input  logic              out_valid,
  input  logic              out_stall,
  input  out_word_t         out_data,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic [TIME_W-1:0] cfg_data,
  output int                fail_count,
  output int                results_owed
);

  logic [TIME_W-1:0] ttl;
  logic              slot_used  [ENTRIES];
  logic [KEY_W-1:0]  slot_key   [ENTRIES];
  logic [TIME_W-1:0] slot_stamp [ENTRIES];
  out_word_t         results_due[$];

  task automatic report_mismatch(string what);
    $display("%0t mismatch: %s", $time, what);
    fail_count++;
  endtask

  function automatic bit slot_live(int i, logic [TIME_W-1:0] now_t);
    logic [TIME_W-1:0] age;
    age = now_t - slot_stamp[i];
    return slot_used[i] && (age < ttl);
  endfunction

  function automatic out_word_t apply_token_op(in_word_t w);
    out_word_t r;
    int        hit;
    int        spot;
    r    = '0;
    hit  = -1;
    spot = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == w.token_key) hit = i;
    end
    case (w.kind)
      KIND_GENERATE: begin
        if (hit >= 0) begin
          slot_stamp[hit] = w.current_time;
        end else begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (spot < 0 && !slot_live(i, w.current_time)) spot = i;
          end
          if (spot >= 0) begin
            slot_used[spot]  = 1'b1;
            slot_key[spot]   = w.token_key;
            slot_stamp[spot] = w.current_time;
          end else begin
            r.table_full = 1'b1;
          end
        end
      end
      KIND_RENEW: begin
        if (hit >= 0 && slot_live(hit, w.current_time)) begin
          slot_stamp[hit] = w.current_time;
          r.renew_done    = 1'b1;
        end
      end
      KIND_COUNT: begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (slot_live(i, w.current_time) && r.unexpired_count != COUNT_MAX)
            r.unexpired_count = r.unexpired_count + 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    if (!rst_n) begin
      ttl = 1;
      for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
      results_due.delete();
      results_owed = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          report_mismatch($sformatf("result word %h with none due", out_data));
        end else begin
          want = results_due.pop_front();
          if (out_data.unexpired_count !== want.unexpired_count)
            report_mismatch($sformatf("unexpired_count %0d, wanted %0d",
                                      out_data.unexpired_count, want.unexpired_count));
          if (out_data.renew_done !== want.renew_done)
            report_mismatch($sformatf("renew_done %b, wanted %b",
                                      out_data.renew_done, want.renew_done));
          if (out_data.table_full !== want.table_full)
            report_mismatch($sformatf("table_full %b, wanted %b",
                                      out_data.table_full, want.table_full));
        end
      end
      if (cfg_valid && cfg_ready) ttl = cfg_data;
      if (in_valid && !in_stall) results_due.push_back(apply_token_op(in_data));
      results_owed = results_due.size();
    end
  end

  final begin
    if (results_due.size() != 0)
      $display("%0d result words still due", results_due.size());
  end

endmodule

// File: tb/sv/token_expiry_table_top_tb.sv
// ----------------------------------------------------------------------------
// token_expiry_table_top_tb
// Drives the token expiry table with a short directed sequence and then
// random phases of mostly generate, renew and count words under several time to
// live settings, with bursty input, a stalling receiver and long hold-offs.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module token_expiry_table_top_tb;
  import tet_pkg::*;

  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES  = 600;
  localparam int POOL_SIZE    = 12;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam logic [KEY_W-1:0]  KEY_MAX   = 25'h1FF_FFFF;
  localparam logic [KEY_W-1:0]  KEY_ALT   = 25'h155_5555;

  typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_EVERY_THIRD} flow_mode_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_word_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_word_t         out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TIME_W-1:0] cfg_data  = '0;

  int                fail_count;
  int                results_owed;
  int                cycle_count  = 0;
  int                words_sent   = 0;
  int                burst_left   = 0;
  int                hold_at_a    = -1;
  int                hold_at_b    = -1;
  logic              hold_off_req = 1'b0;
  logic [TIME_W-1:0] now_t        = '0;
  logic [KEY_W-1:0]  key_pool [POOL_SIZE];

  always #10 clk = ~clk;

  token_expiry_table_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  token_expiry_table_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("[token_expiry_table_top] ERROR");
      $finish;
    end
  end

  // receiver: stall pattern of its own, plus long hold-offs on request
  initial begin
    flow_mode_t mode;
    int         left;
    mode = FLOW_FREE;
    left = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall    = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        mode = flow_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 200);
      end
      left--;
      case (mode)
        FLOW_FREE:  out_stall = 1'b0;
        FLOW_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
        FLOW_HEAVY: out_stall = ($urandom_range(0, 9) < 7);
        default:    out_stall = (left % 3 == 0);
      endcase
    end
  end

  task automatic offer_word(logic [KIND_W-1:0] kd, logic [KEY_W-1:0] k,
                            logic [TIME_W-1:0] t);
    int idle;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = '{kind: kd, token_key: k, current_time: t};
    do @(posedge clk); while (in_stall);
    words_sent++;
    if (words_sent == hold_at_a || words_sent == hold_at_b) hold_off_req = 1'b1;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      idle       = $urandom_range(0, 6);
      if (idle != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
    end
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_ttl(logic [TIME_W-1:0] v);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic run_phase(int n, logic [TIME_W-1:0] step_max);
    int                pick;
    logic [KIND_W-1:0] kd;
    logic [KEY_W-1:0]  k;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      kd = KIND_GENERATE;
      else if (pick < 70) kd = KIND_RENEW;
      else if (pick < 95) kd = KIND_COUNT;
      else                kd = KIND_NONE;
      pick = $urandom_range(0, 99);
      if (pick < 85)      k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 95) k = KEY_W'($urandom);
      else if (pick < 98) k = KEY_MAX;
      else                k = '0;
      pick = $urandom_range(0, 99);
      if (pick < 2)       now_t = now_t - $urandom_range(1, step_max);
      else if (pick < 5)  now_t = now_t + $urandom;
      else                now_t = now_t + $urandom_range(0, step_max);
      offer_word(kd, k, now_t);
    end
  endtask

  initial begin
    // keys built from five 5-bit letter codes
    for (int i = 0; i < POOL_SIZE; i++) begin
      for (int j = 0; j < 5; j++)
        key_pool[i][j*5 +: 5] = 5'($urandom_range(0, 26));
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset time to live of one tick
    offer_word(KIND_COUNT,    '0,      32'd0);
    offer_word(KIND_RENEW,    KEY_ALT, 32'd0);
    offer_word(KIND_GENERATE, '0,      32'd5);
    offer_word(KIND_COUNT,    KEY_MAX, 32'd5);
    offer_word(KIND_COUNT,    '0,      32'd6);
    offer_word(KIND_RENEW,    '0,      32'd6);
    offer_word(KIND_GENERATE, '0,      32'd6);
    offer_word(KIND_NONE,     KEY_MAX, 32'hFFFF_FFFF);
    settle();

    // longest time to live, time wrapping past zero and stepping back
    write_ttl(32'hFFFF_FFFF);
    offer_word(KIND_GENERATE, KEY_MAX, 32'hFFFF_FFF0);
    offer_word(KIND_RENEW,    '0,      32'hFFFF_FFF5);
    offer_word(KIND_COUNT,    '0,      32'hFFFF_FFFF);
    offer_word(KIND_GENERATE, KEY_ALT, 32'd3);
    offer_word(KIND_RENEW,    KEY_MAX, 32'd5);
    offer_word(KIND_COUNT,    KEY_ALT, 32'hFFFF_FFF4);
    settle();

    // zero time to live: everything expired at once
    write_ttl('0);
    offer_word(KIND_GENERATE, 25'h0AA_AAAA, 32'd20);
    offer_word(KIND_COUNT,    '0,           32'd20);
    offer_word(KIND_RENEW,    25'h0AA_AAAA, 32'd20);
    offer_word(KIND_GENERATE, KEY_MAX,      32'd21);
    settle();

    write_ttl(32'd3);
    offer_word(KIND_GENERATE, 25'h042_1084, 32'd100);
    offer_word(KIND_GENERATE, 25'h108_4210, 32'd101);
    offer_word(KIND_COUNT,    '0,           32'd102);
    offer_word(KIND_COUNT,    '0,           32'd103);
    offer_word(KIND_RENEW,    25'h042_1084, 32'd103);
    offer_word(KIND_RENEW,    25'h108_4210, 32'd103);
    offer_word(KIND_GENERATE, 25'h000_0001, 32'd110);
    settle();

    hold_at_a = words_sent + $urandom_range(10, 40);
    hold_at_b = words_sent + $urandom_range(200, 260);
    now_t     = 32'd110;

    write_ttl(32'd20);
    run_phase(50, 32'd8);
    settle();

    write_ttl($urandom_range(1, 500));
    now_t = $urandom;
    run_phase(50, 32'd100);
    settle();

    write_ttl(32'd1);
    run_phase(40, 32'd2);
    settle();

    write_ttl(32'hFFFF_FFFF);
    now_t = $urandom;
    run_phase(50, 32'd1000);
    settle();

    write_ttl($urandom);
    now_t = $urandom;
    run_phase(50, 32'h3FFF_FFFF);
    settle();

    write_ttl($urandom_range(50, 300));
    run_phase(50, 32'd40);
    settle();

    // let any stray result word show up
    repeat (400) @(negedge clk);
    if (fail_count == 0 && results_owed == 0) begin
      $display("[token_expiry_table_top] OK");
    end else begin
      $display("[token_expiry_table_top] ERROR");
    end
    $finish;
  end

endmodule

// File: token_expiry_table_top.f
rtl/tet_pkg.sv
rtl/tet_ram.sv
rtl/token_expiry_table_top.sv
tb/sv/token_expiry_table_checker.sv
tb/sv/token_expiry_table_top_tb.sv
